/* sv/tcgr_pkg.sv */
// Shared types, codes and helper functions for the text console glyph renderer.
`default_nettype none

package tcgr_pkg;

  localparam int IDX_W = 24;
  localparam int CFG_W = 24;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_LOAD = 2'd1,
    OP_SET  = 2'd2
  } op_t;

  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;

  localparam logic [CFG_INDEX_W-1:0] CFG_FB_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_COLUMNS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_ROWS    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FG_COLOR     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_BG_COLOR     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MODE   = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [10:0] font_addr;
    logic [7:0]  font_byte;
    logic [9:0]  new_col;
    logic [9:0]  new_row;
  } in_item_t;

  typedef struct packed {
    logic             pixel_valid;
    logic [IDX_W-1:0] pixel_index;
    logic [23:0]      pixel_value;
    logic             scroll_request;
    logic [9:0]       cursor_col_out;
    logic [9:0]       cursor_row_out;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic             fg_sel;
    logic             fin;
  } pix_t;

  typedef enum logic [2:0] {
    R_IDLE,
    R_ORIGIN,
    R_MUL,
    R_ADDX,
    R_EMIT
  } rast_state_t;

  function automatic logic [10:0] clamp_count(input logic [10:0] v);
    logic [10:0] r;
    if (v == 11'd0) begin
      r = 11'd1;
    end else if (v > 11'd1024) begin
      r = 11'd1024;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [23:0] to565(input logic [23:0] c);
    return {8'd0, c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

`default_nettype wire

/* sv/tcgr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1920
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* sv/tcgr_raster.sv */
// Glyph raster sequencer: walks the glyph bits and steps the pixel index with one shared adder.
`default_nettype none

module tcgr_raster #(
  parameter int GLYPH_WIDTH = 6,
  parameter int GLYPH_HEIGHT = 10,
  parameter int GLYPH_COUNT = 256,
  localparam int GLYPH_BITS = GLYPH_WIDTH * GLYPH_HEIGHT,
  localparam int FONT_BYTES = (GLYPH_COUNT * GLYPH_BITS + 7) / 8,
  localparam int BYTE_AW = $clog2(FONT_BYTES)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [7:0]         code,
  input  wire logic [9:0]         col,
  input  wire logic [9:0]         row,
  input  wire logic [12:0]        fb_width,
  input  wire logic               take,
  input  wire logic [7:0]         rd_data,
  output logic                    busy,
  output logic                    rd_en,
  output logic      [BYTE_AW-1:0] rd_addr,
  output tcgr_pkg::pix_t          pix
);

  import tcgr_pkg::*;

  localparam int BIT_W = BYTE_AW + 3;
  localparam int OY_W = $clog2(GLYPH_HEIGHT * 1024);
  localparam int OX_W = $clog2(GLYPH_WIDTH * 1024);
  localparam int PW = OY_W + 13;
  localparam int SX_W = $clog2(GLYPH_WIDTH);
  localparam int SY_W = $clog2(GLYPH_HEIGHT);

  rast_state_t state, state_next;

  logic [7:0]       code_q;
  logic [9:0]       col_q;
  logic [9:0]       row_q;
  logic             code_ok;
  logic [OY_W-1:0]  oy;
  logic [OX_W-1:0]  ox;
  logic [IDX_W-1:0] step;
  logic [IDX_W-1:0] idx;
  logic [BIT_W-1:0] nbit;
  logic [SX_W-1:0]  sx;
  logic [SY_W-1:0]  sy;

  logic [PW-1:0]    prod;
  logic [IDX_W-1:0] add_b;
  logic [IDX_W-1:0] sum;
  logic             row_end;
  logic             fin;
  logic [BIT_W-1:0] nbit_inc;

  assign row_end  = (sx == SX_W'(GLYPH_WIDTH - 1));
  assign fin      = row_end && (sy == SY_W'(GLYPH_HEIGHT - 1));
  assign nbit_inc = nbit + BIT_W'(1);
  assign prod     = PW'(oy) * PW'(fb_width);

  always_comb begin
    if (state == R_ADDX) begin
      add_b = IDX_W'(ox);
    end else if (row_end) begin
      add_b = step;
    end else begin
      add_b = IDX_W'(1);
    end
    sum = idx + add_b;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      R_IDLE: begin
        if (start) begin
          state_next = R_ORIGIN;
        end
      end
      R_ORIGIN: state_next = R_MUL;
      R_MUL:    state_next = R_ADDX;
      R_ADDX:   state_next = R_EMIT;
      R_EMIT: begin
        if (take && fin) begin
          state_next = R_IDLE;
        end
      end
      default:  state_next = R_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state != R_IDLE);
    rd_en   = 1'b0;
    rd_addr = nbit[BIT_W-1:3];
    pix     = '0;
    unique case (state)
      R_ADDX: begin
        rd_en = 1'b1;
      end
      R_EMIT: begin
        pix.valid  = 1'b1;
        pix.index  = idx;
        pix.fg_sel = code_ok && rd_data[nbit[2:0]];
        pix.fin    = fin;
        rd_addr    = nbit_inc[BIT_W-1:3];
        rd_en      = take && !fin && (nbit[2:0] == 3'd7);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      R_IDLE: begin
        code_q <= code;
        col_q  <= col;
        row_q  <= row;
      end
      R_ORIGIN: begin
        code_ok <= ({1'b0, code_q} < 9'(GLYPH_COUNT));
        oy      <= OY_W'(GLYPH_HEIGHT * row_q);
        ox      <= OX_W'(GLYPH_WIDTH * col_q);
        step    <= IDX_W'(fb_width) - IDX_W'(GLYPH_WIDTH - 1);
        if ({1'b0, code_q} < 9'(GLYPH_COUNT)) begin
          nbit <= BIT_W'(GLYPH_BITS * code_q);
        end else begin
          nbit <= '0;
        end
        sx <= '0;
        sy <= '0;
      end
      R_MUL: begin
        idx <= prod[IDX_W-1:0];
      end
      R_ADDX: begin
        idx <= sum;
      end
      R_EMIT: begin
        if (take && !fin) begin
          idx  <= sum;
          nbit <= nbit_inc;
          if (row_end) begin
            sx <= '0;
            sy <= sy + SY_W'(1);
          end else begin
            sx <= sx + SX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/text_console_glyph_renderer_top.sv */
// Top level of the text console glyph renderer: registers, cursor, font store and result register.
// A transaction that draws nothing gives its one result, registered, in the cycle after acceptance.
// A drawn glyph steps through the raster states ORIGIN, MUL, ADDX and EMIT, and then the result register,
// before its first pixel write; then one pixel write per cycle while results are not stalled. No new
// transaction is taken while a glyph is drawn; others are taken back to back while results are not stalled.
// Reset is synchronous; it clears the cursor and loads the register defaults, not the font store.
`default_nettype none

module text_console_glyph_renderer_top #(
  parameter int GLYPH_WIDTH = 6,
  parameter int GLYPH_HEIGHT = 10,
  parameter int GLYPH_COUNT = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire tcgr_pkg::in_item_t                  item,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output tcgr_pkg::out_item_t                      result,
  input  wire logic                                cfg_we,
  input  wire logic [tcgr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [tcgr_pkg::CFG_W-1:0]          cfg_data
);

  import tcgr_pkg::*;

  localparam int GLYPH_BITS = GLYPH_WIDTH * GLYPH_HEIGHT;
  localparam int FONT_BYTES = (GLYPH_COUNT * GLYPH_BITS + 7) / 8;
  localparam int BYTE_AW = $clog2(FONT_BYTES);

  logic [12:0] fb_width;
  logic [10:0] text_columns;
  logic [10:0] text_rows;
  logic [23:0] fg_color;
  logic [23:0] bg_color;
  logic        color_mode;

  logic [9:0]  cursor_col, cursor_col_next;
  logic [9:0]  cursor_row, cursor_row_next;
  logic        scroll_pend, scroll_calc;

  logic        accept;
  logic        out_free;
  logic        draw;
  logic        status_load;
  logic        pix_load;
  logic        rast_busy;
  logic        rd_en;
  logic [BYTE_AW-1:0] rd_addr;
  logic [7:0]  rd_data;
  logic        font_we;
  pix_t        pix;

  logic [10:0] cols_eff, rows_eff;
  logic [10:0] col_adv, row_adv, col_sat, row_sat;
  logic [23:0] fg_pix, bg_pix;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = rast_busy || !out_free;
  assign accept     = item_valid && !item_stall;
  assign draw       = accept && (item.op == OP_PUT) && (item.char_code != CHAR_CR)
                      && (item.char_code != CHAR_LF);
  assign status_load = accept && !draw;
  assign pix_load    = pix.valid && out_free;
  assign font_we     = accept && (item.op == OP_LOAD) && (item.font_addr < 11'(FONT_BYTES));
  assign fg_pix      = color_mode ? to565(fg_color) : fg_color;
  assign bg_pix      = color_mode ? to565(bg_color) : bg_color;

  always_comb begin
    cols_eff = clamp_count(text_columns);
    rows_eff = clamp_count(text_rows);
    col_adv  = 11'(cursor_col) + 11'd1;
    row_adv  = 11'(cursor_row);
    if (item.char_code == CHAR_CR) begin
      col_adv = '0;
    end else if (item.char_code == CHAR_LF) begin
      col_adv = '0;
      row_adv = row_adv + 11'd1;
    end
    if (col_adv >= cols_eff) begin
      col_adv = '0;
      row_adv = row_adv + 11'd1;
    end
    scroll_calc = 1'b0;
    if (row_adv >= rows_eff) begin
      row_adv     = rows_eff - 11'd1;
      scroll_calc = 1'b1;
    end
    col_sat = ({1'b0, item.new_col} > cols_eff - 11'd1) ? cols_eff - 11'd1
                                                         : {1'b0, item.new_col};
    row_sat = ({1'b0, item.new_row} > rows_eff - 11'd1) ? rows_eff - 11'd1
                                                         : {1'b0, item.new_row};
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    if (accept && (item.op == OP_PUT)) begin
      cursor_col_next = col_adv[9:0];
      cursor_row_next = row_adv[9:0];
    end else if (accept && (item.op == OP_SET)) begin
      cursor_col_next = col_sat[9:0];
      cursor_row_next = row_sat[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width     <= 13'd320;
      text_columns <= 11'd53;
      text_rows    <= 11'd48;
      fg_color     <= 24'hFFFFFF;
      bg_color     <= 24'h000000;
      color_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FB_WIDTH:     fb_width     <= cfg_data[12:0];
        CFG_TEXT_COLUMNS: text_columns <= cfg_data[10:0];
        CFG_TEXT_ROWS:    text_rows    <= cfg_data[10:0];
        CFG_FG_COLOR:     fg_color     <= cfg_data;
        CFG_BG_COLOR:     bg_color     <= cfg_data;
        CFG_COLOR_MODE:   color_mode   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col   <= '0;
      cursor_row   <= '0;
      scroll_pend  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      if (draw) begin
        scroll_pend <= scroll_calc;
      end
      if (status_load || pix_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (status_load) begin
      result.pixel_valid    <= 1'b0;
      result.pixel_index    <= '0;
      result.pixel_value    <= '0;
      result.scroll_request <= (item.op == OP_PUT) && scroll_calc;
      result.cursor_col_out <= cursor_col_next;
      result.cursor_row_out <= cursor_row_next;
      result.last           <= 1'b1;
    end else if (pix_load) begin
      result.pixel_valid    <= 1'b1;
      result.pixel_index    <= pix.index;
      result.pixel_value    <= pix.fg_sel ? fg_pix : bg_pix;
      result.scroll_request <= pix.fin && scroll_pend;
      result.cursor_col_out <= cursor_col;
      result.cursor_row_out <= cursor_row;
      result.last           <= pix.fin;
    end
  end

  tcgr_ram #(
    .WIDTH (8),
    .DEPTH (FONT_BYTES)
  ) u_font_ram (
    .clk     (clk),
    .wr_en   (font_we),
    .wr_addr (item.font_addr[BYTE_AW-1:0]),
    .wr_data (item.font_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tcgr_raster #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .GLYPH_COUNT  (GLYPH_COUNT)
  ) u_raster (
    .clk      (clk),
    .rst      (rst),
    .start    (draw),
    .code     (item.char_code),
    .col      (cursor_col),
    .row      (cursor_row),
    .fb_width (fb_width),
    .take     (out_free),
    .rd_data  (rd_data),
    .busy     (rast_busy),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .pix      (pix)
  );

endmodule

`default_nettype wire

/* dv/text_console_glyph_renderer_checker.sv */
`timescale 1ns / 100ps
// Checker that mirrors the glyph renderer and compares every result transaction.
module text_console_glyph_renderer_checker #(
  parameter int GLYPH_WIDTH = 6,
  parameter int GLYPH_HEIGHT = 10,
  parameter int GLYPH_COUNT = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  input  logic                             item_stall,
  input  tcgr_pkg::in_item_t               item,
  input  logic                             result_valid,
  input  logic                             result_stall,
  input  tcgr_pkg::out_item_t              result,
  input  logic                             cfg_we,
  input  logic [tcgr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tcgr_pkg::CFG_W-1:0]       cfg_data,
  output int                               errors,
  output int                               writes_pending
);
  import tcgr_pkg::*;

  localparam int CELL_BITS = GLYPH_WIDTH * GLYPH_HEIGHT;
  localparam int FONT_BYTES = (GLYPH_COUNT * CELL_BITS + 7) / 8;

  logic [12:0] stride;
  logic [10:0] cols_reg;
  logic [10:0] rows_reg;
  logic [23:0] ink_rgb;
  logic [23:0] paper_rgb;
  logic        mode565;
  int unsigned col_now;
  int unsigned row_now;
  logic [7:0]  glyph_rom [FONT_BYTES];
  out_item_t   writes_due [$];

  initial errors = 0;

  function automatic int unsigned fit_count(input logic [10:0] v);
    return (v == 11'd0) ? 1 : ((v > 11'd1024) ? 1024 : int'(v));
  endfunction

  function automatic logic [23:0] pack565(input logic [23:0] rgb);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = rgb[23:19];
    g6 = rgb[15:10];
    b5 = rgb[7:3];
    return {8'h00, r5, g6, b5};
  endfunction

  function automatic void compare_field(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic render(input in_item_t it);
    out_item_t   w;
    int unsigned ncols;
    int unsigned nrows;
    int unsigned col;
    int unsigned row;
    int unsigned ox;
    int unsigned oy;
    int unsigned bit_no;
    logic        scroll;
    logic        lit;
    logic [23:0] ink;
    logic [23:0] paper;
    w = '0;
    w.last = 1'b1;
    ncols = fit_count(cols_reg);
    nrows = fit_count(rows_reg);
    case (it.op)
      OP_LOAD: begin
        if (it.font_addr < FONT_BYTES) begin
          glyph_rom[it.font_addr] = it.font_byte;
        end
      end
      OP_SET: begin
        col_now = (it.new_col > ncols - 1) ? ncols - 1 : it.new_col;
        row_now = (it.new_row > nrows - 1) ? nrows - 1 : it.new_row;
      end
      OP_PUT: begin
        col = col_now;
        row = row_now;
        scroll = 1'b0;
        if (it.char_code == CHAR_CR) begin
          col = 0;
        end else if (it.char_code == CHAR_LF) begin
          col = 0;
          row++;
        end else begin
          col++;
        end
        if (col >= ncols) begin
          col = 0;
          row++;
        end
        if (row >= nrows) begin
          row = nrows - 1;
          scroll = 1'b1;
        end
        if (it.char_code != CHAR_CR && it.char_code != CHAR_LF) begin
          ink = mode565 ? pack565(ink_rgb) : ink_rgb;
          paper = mode565 ? pack565(paper_rgb) : paper_rgb;
          ox = GLYPH_WIDTH * col_now;
          oy = GLYPH_HEIGHT * row_now;
          col_now = col;
          row_now = row;
          for (int y = 0; y < GLYPH_HEIGHT; y++) begin
            for (int x = 0; x < GLYPH_WIDTH; x++) begin
              bit_no = CELL_BITS * it.char_code + GLYPH_WIDTH * y + x;
              lit = (it.char_code < GLYPH_COUNT) ? glyph_rom[bit_no / 8][bit_no % 8] : 1'b0;
              w.pixel_valid = 1'b1;
              w.pixel_index = 24'((oy + y) * stride + ox + x);
              w.pixel_value = lit ? ink : paper;
              w.last = (y == GLYPH_HEIGHT - 1) && (x == GLYPH_WIDTH - 1);
              w.scroll_request = w.last & scroll;
              w.cursor_col_out = 10'(col_now);
              w.cursor_row_out = 10'(row_now);
              writes_due.push_back(w);
            end
          end
          return;
        end
        col_now = col;
        row_now = row;
        w.scroll_request = scroll;
      end
      default: begin
      end
    endcase
    w.cursor_col_out = 10'(col_now);
    w.cursor_row_out = 10'(row_now);
    writes_due.push_back(w);
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      stride = 13'd320;
      cols_reg = 11'd53;
      rows_reg = 11'd48;
      ink_rgb = 24'hFFFFFF;
      paper_rgb = 24'h000000;
      mode565 = 1'b0;
      col_now = 0;
      row_now = 0;
      writes_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FB_WIDTH:     stride = cfg_data[12:0];
          CFG_TEXT_COLUMNS: cols_reg = cfg_data[10:0];
          CFG_TEXT_ROWS:    rows_reg = cfg_data[10:0];
          CFG_FG_COLOR:     ink_rgb = cfg_data[23:0];
          CFG_BG_COLOR:     paper_rgb = cfg_data[23:0];
          CFG_COLOR_MODE:   mode565 = cfg_data[0];
          default: begin
          end
        endcase
      end
      if (result_valid && !result_stall) begin
        if (writes_due.size() == 0) begin
          $error("result transaction arrived with no expected result pending");
          errors++;
        end else begin
          want = writes_due.pop_front();
          compare_field("pixel_valid", 24'(want.pixel_valid), 24'(result.pixel_valid));
          compare_field("pixel_index", want.pixel_index, result.pixel_index);
          compare_field("pixel_value", want.pixel_value, result.pixel_value);
          compare_field("scroll_request", 24'(want.scroll_request),
                        24'(result.scroll_request));
          compare_field("cursor_col_out", 24'(want.cursor_col_out),
                        24'(result.cursor_col_out));
          compare_field("cursor_row_out", 24'(want.cursor_row_out),
                        24'(result.cursor_row_out));
          compare_field("last", 24'(want.last), 24'(result.last));
        end
      end
      if (item_valid && !item_stall) begin
        render(item);
      end
    end
    writes_pending = writes_due.size();
  end

endmodule

/* dv/text_console_glyph_renderer_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top that drives the glyph renderer and reports the checker's verdict.
module text_console_glyph_renderer_top_tb;
  import tcgr_pkg::*;

  localparam int GW = 6;
  localparam int GH = 10;
  localparam int GC = 256;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  in_item_t               item = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  out_item_t              result;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  int                     errors;
  int                     writes_pending;

  int drawable [$];
  bit quiet = 1'b0;
  int hold_requests = 0;

  text_console_glyph_renderer_top #(
    .GLYPH_WIDTH(GW),
    .GLYPH_HEIGHT(GH),
    .GLYPH_COUNT(GC)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  text_console_glyph_renderer_checker #(
    .GLYPH_WIDTH(GW),
    .GLYPH_HEIGHT(GH),
    .GLYPH_COUNT(GC)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors),
    .writes_pending(writes_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // The receiver stalls at random unless quiet is set, and for a long stretch whenever a hold-off is requested.
  initial begin : receiver
    int hold_left;
    int served;
    hold_left = 0;
    served = 0;
    forever begin
      @(negedge clk);
      if (served != hold_requests) begin
        served = hold_requests;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !quiet && ($urandom_range(99) < 8);
      end
    end
  end

  function automatic in_item_t noise_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  task automatic send(input in_item_t it);
    if (!quiet && $urandom_range(99) < 8) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  task automatic load_byte(input logic [10:0] addr, input logic [7:0] data);
    in_item_t it;
    it = noise_item();
    it.op = OP_LOAD;
    it.font_addr = addr;
    it.font_byte = data;
    send(it);
  endtask

  task automatic load_glyph(input int code, input int pattern);
    for (int a = (GW * GH * code) / 8; a <= (GW * GH * code + GW * GH - 1) / 8; a++) begin
      load_byte(11'(a), (pattern < 0) ? 8'($urandom) : 8'(pattern));
    end
    drawable.push_back(code);
  endtask

  task automatic put_char(input logic [7:0] code);
    in_item_t it;
    it = noise_item();
    it.op = OP_PUT;
    it.char_code = code;
    send(it);
  endtask

  task automatic set_cursor(input logic [9:0] c, input logic [9:0] r);
    in_item_t it;
    it = noise_item();
    it.op = OP_SET;
    it.new_col = c;
    it.new_row = r;
    send(it);
  endtask

  task automatic odd_op();
    in_item_t it;
    it = noise_item();
    it.op = OP_UNKNOWN;
    send(it);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (writes_pending != 0) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [23:0] fb, input logic [23:0] cols,
                            input logic [23:0] rows, input logic [23:0] fg,
                            input logic [23:0] bg, input logic [23:0] mode);
    drain();
    put_reg(CFG_FB_WIDTH, fb);
    put_reg(CFG_TEXT_COLUMNS, cols);
    put_reg(CFG_TEXT_ROWS, rows);
    put_reg(CFG_FG_COLOR, fg);
    put_reg(CFG_BG_COLOR, bg);
    put_reg(CFG_COLOR_MODE, mode);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    int pick;
    logic [10:0] addr;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        put_char(8'(drawable[$urandom_range(drawable.size() - 1)]));
      end else if (pick < 50) begin
        put_char($urandom_range(1) ? CHAR_CR : CHAR_LF);
      end else if (pick < 62) begin
        load_glyph($urandom_range(GC - 1), -1);
      end else if (pick < 75) begin
        set_cursor(10'($urandom), 10'($urandom));
      end else if (pick < 90) begin
        addr = 11'($urandom);
        load_byte(addr, 8'($urandom));
      end else begin
        odd_op();
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    load_glyph(0, 8'hFF);
    load_glyph(GC - 1, 8'h00);
    load_byte(11'd1919, 8'hA5);
    load_byte(11'h7FF, 8'hFF);
    odd_op();
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CHAR_CR);
    put_char(CHAR_LF);
    set_cursor(10'h3FF, 10'h3FF);
    put_char(8'hFF);
    set_cursor(10'h000, 10'h3FF);
    put_char(CHAR_LF);

    set_config(24'd4096, 24'd1, 24'd1, 24'($urandom), 24'($urandom), 24'd1);
    random_phase(25);

    set_config(24'hFFE000, 24'hFFFFFF, 24'hFFF800, 24'hFFFFFF, 24'h000000, 24'd0);
    random_phase(25);

    set_config(24'hFFFFFF, 24'd1024, 24'd1024, 24'h000000, 24'hFFFFFF, 24'd1);
    hold_requests++;
    repeat (10) put_char(8'(drawable[$urandom_range(drawable.size() - 1)]));
    random_phase(25);
    set_cursor(10'd1000, 10'd1000);

    set_config(24'($urandom_range(1, 400)), 24'($urandom_range(2, 8)),
               24'($urandom_range(1, 4)), 24'($urandom), 24'($urandom),
               24'($urandom_range(1)));
    random_phase(25);

    set_config(24'($urandom_range(1, 400)), 24'($urandom_range(1, 12)),
               24'($urandom_range(1, 6)), 24'($urandom), 24'($urandom),
               24'($urandom_range(1)));
    quiet = 1'b1;
    random_phase(25);
    quiet = 1'b0;

    set_config(24'($urandom_range(1, 4096)), 24'($urandom_range(1, 1024)),
               24'($urandom_range(1, 1024)), 24'($urandom), 24'($urandom),
               24'($urandom_range(1)));
    random_phase(25);

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
